>>> hw/rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mfd_pkg.sv
`default_nettype none

package mfd_pkg;

  localparam int MAX_LENGTH_BYTES = 4;
  localparam logic [2:0] LEN_BYTES_MAX = 3'(MAX_LENGTH_BYTES);

  localparam logic [3:0] T_CONNACK  = 4'd2;
  localparam logic [3:0] T_PUBLISH  = 4'd3;
  localparam logic [3:0] T_SUBACK   = 4'd9;
  localparam logic [3:0] T_PINGRESP = 4'd13;

  localparam logic [2:0] CLS_HEADER  = 3'd0;
  localparam logic [2:0] CLS_BODY    = 3'd1;
  localparam logic [2:0] CLS_TOPIC   = 3'd2;
  localparam logic [2:0] CLS_PAYLOAD = 3'd3;
  localparam logic [2:0] CLS_SKIP    = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_LEN   = 2'd1;
  localparam logic [1:0] ST_MISMATCH  = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  localparam logic [7:0] SUBACK_FAILURE = 8'h80;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  byte_class;
    logic [7:0]  data_byte;
    logic        frame_done;
    logic [1:0]  frame_status;
    logic [3:0]  packet_type;
    logic [3:0]  packet_flags;
    logic [27:0] remaining_length;
    logic        session_present;
    logic [7:0]  return_code;
    logic [15:0] packet_ident;
    logic        ack_success;
    logic [15:0] topic_length;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/mfd_in_reg.sv
`default_nettype none

module mfd_in_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       rx_byte,
  input  logic             frame_last,
  input  logic             take,
  output logic             word_valid,
  output mfd_pkg::in_word_t word
);
  import mfd_pkg::*;

  logic load;

  assign in_stall = word_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (load) begin
      word_valid <= 1'b1;
    end else if (take) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word.data <= rx_byte;
      word.last <= frame_last;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mfd_parser.sv
`default_nettype none

module mfd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  mfd_pkg::in_word_t word,
  output mfd_pkg::res_t     res
);
  import mfd_pkg::*;

  typedef enum logic [1:0] {PH_FIRST, PH_LEN, PH_BODY, PH_DRAIN} phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  type_reg, type_next;
  logic [3:0]  flags_reg, flags_next;
  logic [27:0] len_accum, len_next;
  logic [2:0]  len_cnt, len_cnt_next;
  logic [27:0] body_cnt, body_next;
  logic [15:0] topic_len, topic_next;
  logic        session, session_next;
  logic [7:0]  code, code_next;
  logic [15:0] ident, ident_next;
  logic [1:0]  err, err_next;

  logic [7:0]  b;
  logic [27:0] len_add;
  logic [2:0]  cls;
  logic        in_header;
  logic        qos;
  logic [16:0] topic_end;
  logic [17:0] ident_end;
  logic        qos_n;
  logic [17:0] need_n;
  logic [1:0]  body_st;
  logic [1:0]  status;
  logic        ok;

  assign b         = word.data;
  assign qos       = flags_reg[2:1] != 2'b00;
  assign topic_end = {1'b0, topic_len} + 17'd2;
  assign ident_end = {1'b0, topic_end} + 18'd2;

  always_comb begin
    case (len_cnt[1:0])
      2'd0:    len_add = {21'b0, b[6:0]};
      2'd1:    len_add = {14'b0, b[6:0], 7'b0};
      2'd2:    len_add = {7'b0, b[6:0], 14'b0};
      default: len_add = {b[6:0], 21'b0};
    endcase
  end

  always_comb begin
    phase_next   = phase;
    type_next    = type_reg;
    flags_next   = flags_reg;
    len_next     = len_accum;
    len_cnt_next = len_cnt;
    body_next    = body_cnt;
    topic_next   = topic_len;
    session_next = session;
    code_next    = code;
    ident_next   = ident;
    err_next     = err;
    cls          = CLS_HEADER;
    in_header    = 1'b0;
    case (phase)
      PH_FIRST: begin
        type_next    = b[7:4];
        flags_next   = b[3:0];
        len_next     = '0;
        len_cnt_next = '0;
        body_next    = '0;
        topic_next   = '0;
        session_next = 1'b0;
        code_next    = '0;
        ident_next   = '0;
        err_next     = ST_OK;
        phase_next   = PH_LEN;
        in_header    = 1'b1;
      end
      PH_LEN: begin
        if (len_cnt >= LEN_BYTES_MAX) begin
          err_next   = ST_BAD_LEN;
          phase_next = PH_DRAIN;
          cls        = CLS_SKIP;
        end else begin
          len_next     = len_accum + len_add;
          len_cnt_next = len_cnt + 3'd1;
          if (b[7]) begin
            in_header = 1'b1;
          end else begin
            phase_next = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (body_cnt >= len_accum) begin
          cls = CLS_SKIP;
          if (err == ST_OK) begin
            err_next = ST_MISMATCH;
          end
        end else begin
          body_next = body_cnt + 28'd1;
          cls       = CLS_BODY;
          case (type_reg)
            T_CONNACK: begin
              if (body_cnt == 28'd0) begin
                session_next = b[0];
              end else if (body_cnt == 28'd1) begin
                code_next = b;
              end
            end
            T_SUBACK: begin
              if (body_cnt == 28'd0) begin
                ident_next = {b, 8'h00};
              end else if (body_cnt == 28'd1) begin
                ident_next = {ident[15:8], b};
              end else if (body_cnt == 28'd2) begin
                code_next = b;
              end
            end
            T_PUBLISH: begin
              if (body_cnt == 28'd0) begin
                topic_next = {b, 8'h00};
                cls        = CLS_SKIP;
              end else if (body_cnt == 28'd1) begin
                topic_next = {topic_len[15:8], b};
                cls        = CLS_SKIP;
              end else if (body_cnt < 28'(topic_end)) begin
                cls = CLS_TOPIC;
              end else if (qos && body_cnt < 28'(ident_end)) begin
                cls = CLS_SKIP;
              end else begin
                cls = CLS_PAYLOAD;
              end
            end
            default: cls = CLS_BODY;
          endcase
        end
      end
      default: cls = CLS_SKIP;
    endcase
    if (word.last) begin
      phase_next = PH_FIRST;
    end
  end

  // end-of-frame summary, from the updated state
  assign qos_n  = flags_next[2:1] != 2'b00;
  assign need_n = {2'b0, topic_next} + 18'd2 + (qos_n ? 18'd2 : 18'd0);

  always_comb begin
    body_st = ST_OK;
    case (type_next)
      T_CONNACK: begin
        if (body_next != 28'd2) body_st = ST_MALFORMED;
      end
      T_SUBACK: begin
        if (body_next < 28'd3) body_st = ST_MALFORMED;
      end
      T_PUBLISH: begin
        if (body_next < 28'd2 || body_next < 28'(need_n)) body_st = ST_MALFORMED;
      end
      default: body_st = ST_OK;
    endcase
    if (!word.last) begin
      status = ST_OK;
    end else if (in_header || err_next == ST_BAD_LEN) begin
      status = ST_BAD_LEN;
    end else if (err_next == ST_MISMATCH || body_next != len_next) begin
      status = ST_MISMATCH;
    end else begin
      status = body_st;
    end
  end

  assign ok = word.last && status == ST_OK;

  always_comb begin
    res.byte_class       = cls;
    res.data_byte        = b;
    res.frame_done       = word.last;
    res.frame_status     = status;
    res.packet_type      = word.last ? type_next : 4'd0;
    res.packet_flags     = word.last ? flags_next : 4'd0;
    res.remaining_length = (word.last && status != ST_BAD_LEN) ? len_next : 28'd0;
    res.session_present  = ok ? session_next : 1'b0;
    res.return_code      = ok ? code_next : 8'd0;
    res.packet_ident     = ok ? ident_next : 16'd0;
    res.topic_length     = (ok && type_next == T_PUBLISH) ? topic_next : 16'd0;
    res.ack_success      = 1'b0;
    if (ok) begin
      case (type_next)
        T_CONNACK:  res.ack_success = code_next == 8'd0;
        T_SUBACK:   res.ack_success = code_next != SUBACK_FAILURE;
        T_PUBLISH:  res.ack_success = 1'b1;
        T_PINGRESP: res.ack_success = 1'b1;
        default:    res.ack_success = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      type_reg  <= '0;
      flags_reg <= '0;
      len_accum <= '0;
      len_cnt   <= '0;
      body_cnt  <= '0;
      topic_len <= '0;
      session   <= 1'b0;
      code      <= '0;
      ident     <= '0;
      err       <= ST_OK;
    end else if (step) begin
      phase     <= phase_next;
      type_reg  <= type_next;
      flags_reg <= flags_next;
      len_accum <= len_next;
      len_cnt   <= len_cnt_next;
      body_cnt  <= body_next;
      topic_len <= topic_next;
      session   <= session_next;
      code      <= code_next;
      ident     <= ident_next;
      err       <= err_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mqtt_frame_decoder.sv
// Channel  Handshake             Payload
// in       in_valid / in_stall   rx_byte, frame_last
// out      out_valid / out_stall byte_class .. topic_length
//
// One word per cycle sustained while out_stall is low; the input register and the
// result register lie around the parser step.
// Synchronous active-high rst clears the parser to await a first byte.
// A stalled result holds; one more word waits in the input register.
// in_stall rises only when both registers are full and out_stall is high.
`default_nettype none

module mqtt_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        frame_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  byte_class,
  output logic [7:0]  data_byte,
  output logic        frame_done,
  output logic [1:0]  frame_status,
  output logic [3:0]  packet_type,
  output logic [3:0]  packet_flags,
  output logic [27:0] remaining_length,
  output logic        session_present,
  output logic [7:0]  return_code,
  output logic [15:0] packet_ident,
  output logic        ack_success,
  output logic [15:0] topic_length
);
  import mfd_pkg::*;

  `include "assert_macros.svh"

  logic     word_valid;
  in_word_t word;
  res_t     res;
  res_t     res_q;
  logic     take;

  assign take = word_valid && (!out_valid || !out_stall);

  mfd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .frame_last (frame_last),
    .take       (take),
    .word_valid (word_valid),
    .word       (word)
  );

  mfd_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .word (word),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res;
    end
  end

  assign byte_class       = res_q.byte_class;
  assign data_byte        = res_q.data_byte;
  assign frame_done       = res_q.frame_done;
  assign frame_status     = res_q.frame_status;
  assign packet_type      = res_q.packet_type;
  assign packet_flags     = res_q.packet_flags;
  assign remaining_length = res_q.remaining_length;
  assign session_present  = res_q.session_present;
  assign return_code      = res_q.return_code;
  assign packet_ident     = res_q.packet_ident;
  assign ack_success      = res_q.ack_success;
  assign topic_length     = res_q.topic_length;

  `ASSERT_IMPL(a_summary_idle, out_valid && !frame_done, frame_status == ST_OK && !ack_success, "summary set off frame end")
  `ASSERT_IMPL(a_bad_len_zero, out_valid && frame_status == ST_BAD_LEN, remaining_length == 28'd0, "length kept on bad field")
  `ASSERT_IMPL(a_no_ack_on_err, out_valid && frame_status != ST_OK, !ack_success && topic_length == 16'd0, "ack on failed frame")
  `ASSERT_IMPL(a_empty_ready, !out_valid, !in_stall, "stall with empty result register")
  `ASSERT_NEXT(a_accept_held, in_valid && !in_stall, word_valid, "accepted word lost")

endmodule

`default_nettype wire

>>> sim/tb_mqtt_frame_decoder.sv
`timescale 1ns / 1ps

module tb_mqtt_frame_decoder;
  import mfd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 475;

  typedef enum logic [1:0] {AWAIT_FIRST, IN_LENGTH, IN_BODY, DRAINING} parse_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        frame_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  byte_class;
  logic [7:0]  data_byte;
  logic        frame_done;
  logic [1:0]  frame_status;
  logic [3:0]  packet_type;
  logic [3:0]  packet_flags;
  logic [27:0] remaining_length;
  logic        session_present;
  logic [7:0]  return_code;
  logic [15:0] packet_ident;
  logic        ack_success;
  logic [15:0] topic_length;

  mqtt_frame_decoder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .frame_last(frame_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .byte_class(byte_class),
    .data_byte(data_byte),
    .frame_done(frame_done),
    .frame_status(frame_status),
    .packet_type(packet_type),
    .packet_flags(packet_flags),
    .remaining_length(remaining_length),
    .session_present(session_present),
    .return_code(return_code),
    .packet_ident(packet_ident),
    .ack_success(ack_success),
    .topic_length(topic_length)
  );

  // decoder state mirror
  parse_state_t parse_state = AWAIT_FIRST;
  logic [3:0]  p_type = '0;
  logic [3:0]  p_flags = '0;
  logic [27:0] len_acc = '0;
  logic [2:0]  len_cnt = '0;
  logic [27:0] body_cnt = '0;
  logic [15:0] topic_len = '0;
  logic        sess = 1'b0;
  logic [7:0]  code = '0;
  logic [15:0] ident = '0;
  logic [1:0]  err = ST_OK;

  in_word_t   byte_q[$];
  res_t       decoded_q[$];
  logic [7:0] fb[$];
  in_word_t   next_word;
  res_t       want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int queued_bytes = 0;
  int cycle_count = 0;

  function automatic logic [2:0] body_class(logic [7:0] b);
    int unsigned i, tend;
    i = body_cnt;
    tend = 2 + topic_len;
    if (p_type == T_CONNACK) begin
      if (i == 0) sess = b[0];
      else if (i == 1) code = b;
      return CLS_BODY;
    end
    if (p_type == T_SUBACK) begin
      if (i == 0) ident = {b, 8'h00};
      else if (i == 1) ident[7:0] = b;
      else if (i == 2) code = b;
      return CLS_BODY;
    end
    if (p_type == T_PUBLISH) begin
      if (i == 0) begin
        topic_len = {b, 8'h00};
        return CLS_SKIP;
      end
      if (i == 1) begin
        topic_len[7:0] = b;
        return CLS_SKIP;
      end
      if (i < tend) return CLS_TOPIC;
      if (p_flags[2:1] != 2'b00 && i < tend + 2) return CLS_SKIP;
      return CLS_PAYLOAD;
    end
    return CLS_BODY;
  endfunction

  function automatic logic [1:0] body_check();
    int unsigned n, need;
    n = body_cnt;
    if (p_type == T_CONNACK && n != 2) return ST_MALFORMED;
    if (p_type == T_SUBACK && n < 3) return ST_MALFORMED;
    if (p_type == T_PUBLISH) begin
      if (n < 2) return ST_MALFORMED;
      need = 2 + topic_len + ((p_flags[2:1] != 2'b00) ? 2 : 0);
      if (n < need) return ST_MALFORMED;
    end
    return ST_OK;
  endfunction

  function automatic res_t decode_byte(logic [7:0] b, logic last);
    res_t r;
    logic [2:0] cls;
    logic [1:0] st;
    logic in_hdr;
    r = '0;
    cls = CLS_HEADER;
    in_hdr = 1'b0;
    case (parse_state)
      AWAIT_FIRST: begin
        p_type = b[7:4];
        p_flags = b[3:0];
        len_acc = '0;
        len_cnt = '0;
        body_cnt = '0;
        topic_len = '0;
        sess = 1'b0;
        code = '0;
        ident = '0;
        err = ST_OK;
        parse_state = IN_LENGTH;
        in_hdr = 1'b1;
      end
      IN_LENGTH: begin
        if (len_cnt >= LEN_BYTES_MAX) begin
          err = ST_BAD_LEN;
          parse_state = DRAINING;
          cls = CLS_SKIP;
        end else begin
          len_acc = len_acc + (28'(b[6:0]) << (7 * len_cnt[1:0]));
          len_cnt = len_cnt + 3'd1;
          if (b[7]) in_hdr = 1'b1;
          else parse_state = IN_BODY;
        end
      end
      IN_BODY: begin
        if (body_cnt >= len_acc) begin
          cls = CLS_SKIP;
          if (err == ST_OK) err = ST_MISMATCH;
        end else begin
          cls = body_class(b);
          body_cnt = body_cnt + 28'd1;
        end
      end
      default: cls = CLS_SKIP;
    endcase
    r.byte_class = cls;
    r.data_byte = b;
    r.frame_done = last;
    if (last) begin
      if (in_hdr || err == ST_BAD_LEN) st = ST_BAD_LEN;
      else if (err == ST_MISMATCH || body_cnt != len_acc) st = ST_MISMATCH;
      else st = body_check();
      r.frame_status = st;
      r.packet_type = p_type;
      r.packet_flags = p_flags;
      r.remaining_length = (st == ST_BAD_LEN) ? 28'd0 : len_acc;
      if (st == ST_OK) begin
        r.session_present = sess;
        r.return_code = code;
        r.packet_ident = ident;
        r.topic_length = (p_type == T_PUBLISH) ? topic_len : 16'd0;
        case (p_type)
          T_CONNACK: r.ack_success = (code == 8'd0);
          T_SUBACK: r.ack_success = (code != SUBACK_FAILURE);
          T_PUBLISH, T_PINGRESP: r.ack_success = 1'b1;
          default: r.ack_success = 1'b0;
        endcase
      end
      parse_state = AWAIT_FIRST;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < 100) $display("mismatch at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [27:0] got, logic [27:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
  endtask

  task automatic commit_frame();
    in_word_t w;
    int i;
    for (i = 0; i < fb.size(); i++) begin
      w.data = fb[i];
      w.last = (i == fb.size() - 1);
      byte_q.insert(byte_q.size(), w);
    end
    queued_bytes += fb.size();
    fb = {};
  endtask

  task automatic put_length(int unsigned v, int groups);
    int g;
    for (g = 0; g < groups; g++) begin
      fb.insert(fb.size(), {(g < groups - 1) ? 1'b1 : 1'b0, v[6:0]});
      v = v >> 7;
    end
  endtask

  task automatic build_random_frame();
    logic [7:0] body[$];
    logic [3:0] ptype, pflags;
    int unsigned declared, tl;
    int n, i, groups, pick, mode;
    pick = $urandom_range(0, 99);
    mode = $urandom_range(0, 99);
    pflags = 4'($urandom);
    if (mode >= 94) begin
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++) fb.insert(fb.size(), 8'($urandom));
      commit_frame();
      return;
    end
    if (pick < 15) begin
      ptype = T_CONNACK;
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : 2;
      for (i = 0; i < n; i++) body.insert(body.size(), 8'($urandom));
      if (n > 1 && $urandom_range(0, 1) == 0) body[1] = 8'h00;
    end else if (pick < 30) begin
      ptype = T_SUBACK;
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : $urandom_range(3, 6);
      for (i = 0; i < n; i++) body.insert(body.size(), 8'($urandom));
      if (n > 2 && $urandom_range(0, 2) == 0) body[2] = SUBACK_FAILURE;
    end else if (pick < 60) begin
      ptype = T_PUBLISH;
      tl = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 600) : $urandom_range(0, 6);
      body.insert(body.size(), tl[15:8]);
      body.insert(body.size(), tl[7:0]);
      for (i = 0; i < tl; i++) body.insert(body.size(), 8'($urandom));
      if (pflags[2:1] != 2'b00) begin
        body.insert(body.size(), 8'($urandom));
        body.insert(body.size(), 8'($urandom));
      end
      n = $urandom_range(0, 5);
      for (i = 0; i < n; i++) body.insert(body.size(), 8'($urandom));
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(0, body.size() - 1);
        while (body.size() > n) void'(body.pop_back());
      end else if ($urandom_range(0, 9) == 0) begin
        // random declared topic length, usually malformed
        body[0] = 8'($urandom);
        body[1] = 8'($urandom);
      end
    end else if (pick < 70) begin
      ptype = T_PINGRESP;
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
      for (i = 0; i < n; i++) body.insert(body.size(), 8'($urandom));
    end else begin
      ptype = 4'($urandom);
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) body.insert(body.size(), 8'($urandom));
    end

    fb.insert(fb.size(), {ptype, pflags});
    declared = body.size();
    if (mode < 8) begin
      // frame cut inside the header
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) fb.insert(fb.size(), {1'b1, 7'($urandom)});
    end else if (mode < 14) begin
      for (i = 0; i < 4; i++) fb.insert(fb.size(), {1'b1, 7'($urandom)});
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) fb.insert(fb.size(), 8'($urandom));
      for (i = 0; i < body.size(); i++) fb.insert(fb.size(), body[i]);
    end else begin
      if (mode < 22)
        declared = ($urandom_range(0, 1) == 0) ? declared + $urandom_range(1, 3)
                                               : $urandom_range(0, 28'hFFFFFFF);
      groups = 1;
      while (groups < 4 && (declared >> (7 * groups)) != 0) groups++;
      if (mode >= 22 && mode < 28) groups = $urandom_range(groups, 4);
      put_length(declared, groups);
      for (i = 0; i < body.size(); i++) fb.insert(fb.size(), body[i]);
      if (mode >= 28 && mode < 36) begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) fb.insert(fb.size(), 8'($urandom));
      end
    end
    commit_frame();
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid || decoded_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  // driver: one word per handshake
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        decoded_q.insert(decoded_q.size(), decode_byte(rx_byte, frame_last));
      if (!in_valid || !in_stall) begin
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_word = byte_q.pop_front();
          in_valid <= 1'b1;
          rx_byte <= next_word.data;
          frame_last <= next_word.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = decoded_q.pop_front();
          check_field("byte_class", 28'(byte_class), 28'(want.byte_class));
          check_field("data_byte", 28'(data_byte), 28'(want.data_byte));
          check_field("frame_done", 28'(frame_done), 28'(want.frame_done));
          check_field("frame_status", 28'(frame_status), 28'(want.frame_status));
          check_field("packet_type", 28'(packet_type), 28'(want.packet_type));
          check_field("packet_flags", 28'(packet_flags), 28'(want.packet_flags));
          check_field("remaining_length", remaining_length, want.remaining_length);
          check_field("session_present", 28'(session_present),
                      28'(want.session_present));
          check_field("return_code", 28'(return_code), 28'(want.return_code));
          check_field("packet_ident", 28'(packet_ident), 28'(want.packet_ident));
          check_field("ack_success", 28'(ack_success), 28'(want.ack_success));
          check_field("topic_length", 28'(topic_length), 28'(want.topic_length));
        end
        results_seen++;
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** mqtt_frame_decoder: FAILED **");
      $finish;
    end
  end

  initial begin
    int phase_no, target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    fb = {8'hF5};
    commit_frame();
    fb = {8'h20, 8'h82};
    commit_frame();
    fb = {8'h20, 8'h02, 8'h01, 8'h00};
    commit_frame();
    fb = {8'h90, 8'h03, 8'h12, 8'h34, SUBACK_FAILURE};
    commit_frame();
    fb = {8'hD0, 8'h00};
    commit_frame();
    fb = {8'h3A, 8'h05, 8'h00, 8'h01, 8'hFF, 8'hAB, 8'hCD};
    commit_frame();
    fb = {8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    commit_frame();
    wait_drained();

    for (phase_no = 0; phase_no < 4; phase_no++) begin
      case (phase_no)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      target = queued_bytes + PHASE_BYTES;
      while (queued_bytes < target) build_random_frame();
      // sender holds off until every result is back
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0 && decoded_q.size() == 0)
      $display("** mqtt_frame_decoder: PASSED **");
    else
      $display("** mqtt_frame_decoder: FAILED **");
    $finish;
  end

endmodule
